FILE: sv/first_fit_partition_allocator_defines.svh
// Assertion macros shared by the allocator RTL.
`ifndef FIRST_FIT_PARTITION_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_PARTITION_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FFPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, checked outside reset.
`define FFPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

FILE: sv/ffpa_pkg.sv
// Shared types and constants for the first-fit partition allocator.
package ffpa_pkg;

  localparam int MAX_PARTITIONS_DEF = 16;
  localparam int SIZE_BITS_DEF      = 16;

  localparam int IDX_PORT_W  = 4;
  localparam int SIZE_PORT_W = 16;
  localparam int REQ_W       = 16;
  localparam int CFG_W       = 5;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_ALLOC = 1'b1
  } op_t;

  // Control part of a request walking the cell chain.
  typedef struct packed {
    logic valid;
    op_t  op;
    logic hit;
  } tok_ctl_t;

endpackage

FILE: sv/ffpa_cell.sv
// One partition cell: holds a size and free mark, serves the request passing by.
`include "first_fit_partition_allocator_defines.svh"

module ffpa_cell
  import ffpa_pkg::*;
#(
  parameter int CELL_ID   = 0,
  parameter int IDX_W     = 4,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [CFG_W-1:0]      in_use_i,
  input  tok_ctl_t              ctl_i,
  input  logic [IDX_PORT_W-1:0] idx_i,
  input  logic [SIZE_BITS-1:0]  size_i,
  input  logic [IDX_W-1:0]      which_i,
  input  logic [REQ_W-1:0]      req_i,
  output tok_ctl_t              ctl_r,
  output logic [IDX_PORT_W-1:0] idx_r,
  output logic [SIZE_BITS-1:0]  size_r,
  output logic [IDX_W-1:0]      which_r,
  output logic [REQ_W-1:0]      req_r
);

  localparam logic [31:0] ID_L = CELL_ID;

  logic [SIZE_BITS-1:0] part_size_r;
  logic                 free_r;
  logic                 free_nxt;
  logic                 load_hit;
  logic                 active;
  logic                 fit;
  tok_ctl_t             ctl_nxt;
  logic [IDX_W-1:0]     which_nxt;

  always_comb begin
    load_hit  = ctl_i.valid && (ctl_i.op == OP_LOAD) && (32'(idx_i) == ID_L);
    active    = 32'(in_use_i) > ID_L;
    fit       = ctl_i.valid && (ctl_i.op == OP_ALLOC) && !ctl_i.hit && active &&
                free_r && (part_size_r >= size_i);
    ctl_nxt   = ctl_i;
    which_nxt = which_i;
    free_nxt  = free_r;
    if (load_hit) begin
      free_nxt = 1'b1;
    end else if (fit) begin
      free_nxt      = 1'b0;
      ctl_nxt.hit   = 1'b1;
      which_nxt     = IDX_W'(CELL_ID);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= 1'b0;
      ctl_r  <= '0;
    end else begin
      free_r <= free_nxt;
      ctl_r  <= ctl_nxt;
    end
  end

  // Stored size and passing payload need no reset.
  always_ff @(posedge clk) begin
    if (load_hit) begin
      part_size_r <= size_i;
    end
    idx_r   <= idx_i;
    size_r  <= size_i;
    which_r <= which_nxt;
    req_r   <= req_i;
  end

  `FFPA_ASSERT_NXT(a_fit_takes, fit, !free_r && ctl_r.hit)
  `FFPA_ASSERT_NXT(a_load_frees, load_hit, free_r && (part_size_r == $past(size_i)))
  `FFPA_ASSERT_IMP(a_fit_needs_room, fit, ID_L < 32'(in_use_i))

endmodule

FILE: sv/first_fit_partition_allocator.sv
// Top level of the first-fit partition allocator: config register, counter, cell chain.
//
// Usage:
//   Input requests are taken on an edge with start high and busy low. A load
//   (in_operation = 0) writes the size of partition in_partition_index and
//   marks it free; it gives no result. An allocate (in_operation = 1) searches
//   partitions 0 .. partitions_in_use-1 for the first free one that is large
//   enough, takes it, and returns one result.
//   Requests walk a chain of MAX_PARTITIONS cells, one cell per cycle, so a
//   new request can be taken every cycle and results leave in request order.
//   Latency is set by the chain: a request passes all MAX_PARTITIONS cell
//   registers before its result is taken. Throughput is one request per cycle.
//   Results appear for one cycle with out_valid high; the receiver cannot
//   stall, so every result must be taken as it appears.
//   The cfg channel writes partitions_in_use (cfg_ready is always high); write
//   it only while no request is in the chain.
//   Synchronous reset clears all free marks, the request counter and the
//   config register; busy is high in the cycle after reset.
`include "first_fit_partition_allocator_defines.svh"

module first_fit_partition_allocator
  import ffpa_pkg::*;
#(
  parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF,
  parameter int SIZE_BITS      = SIZE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_operation,
  input  logic [IDX_PORT_W-1:0]  in_partition_index,
  input  logic [SIZE_PORT_W-1:0] in_size_value,
  output logic                   out_valid,
  output logic                   out_granted,
  output logic [IDX_PORT_W-1:0]  out_granted_partition,
  output logic [REQ_W-1:0]       out_request_number,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data
);

  localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int N     = MAX_PARTITIONS;

  logic [CFG_W-1:0]     in_use_r;
  logic [REQ_W-1:0]     req_cnt_r;
  logic [REQ_W-1:0]     req_cnt_nxt;
  logic                 busy_r;
  logic                 accept;

  tok_ctl_t             ctl   [N+1];
  logic [IDX_PORT_W-1:0] idx  [N+1];
  logic [SIZE_BITS-1:0] size  [N+1];
  logic [IDX_W-1:0]     which [N+1];
  logic [REQ_W-1:0]     req   [N+1];

  assign busy      = busy_r;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy_r;

  always_comb begin
    req_cnt_nxt = req_cnt_r;
    if (accept && (op_t'(in_operation) == OP_ALLOC)) begin
      req_cnt_nxt = req_cnt_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r  <= '0;
      req_cnt_r <= '0;
      busy_r    <= 1'b1;
    end else begin
      busy_r    <= 1'b0;
      req_cnt_r <= req_cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        in_use_r <= cfg_data;
      end
    end
  end

  // Chain head: the accepted request, numbered on entry.
  assign ctl[0]   = '{valid: accept, op: op_t'(in_operation), hit: 1'b0};
  assign idx[0]   = in_partition_index;
  assign size[0]  = SIZE_BITS'(in_size_value);
  assign which[0] = '0;
  assign req[0]   = req_cnt_r + 16'd1;

  for (genvar k = 0; k < N; k++) begin : g_cell
    ffpa_cell #(
      .CELL_ID  (k),
      .IDX_W    (IDX_W),
      .SIZE_BITS(SIZE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_use_i(in_use_r),
      .ctl_i   (ctl[k]),
      .idx_i   (idx[k]),
      .size_i  (size[k]),
      .which_i (which[k]),
      .req_i   (req[k]),
      .ctl_r   (ctl[k+1]),
      .idx_r   (idx[k+1]),
      .size_r  (size[k+1]),
      .which_r (which[k+1]),
      .req_r   (req[k+1])
    );
  end

  assign out_valid             = ctl[N].valid && (ctl[N].op == OP_ALLOC);
  assign out_granted           = ctl[N].hit;
  assign out_granted_partition = IDX_PORT_W'(which[N]);
  assign out_request_number    = req[N];

  `FFPA_ASSERT_IMP(a_no_grant_zero, out_valid && !out_granted, which[N] == '0)
  `FFPA_ASSERT_IMP(a_grant_in_use, out_valid && out_granted,
                   32'(which[N]) < 32'(in_use_r))
  `FFPA_ASSERT_IMP(a_req_seq, out_valid && $past(out_valid),
                   out_request_number == $past(out_request_number) + 16'd1)

endmodule
